@@ sv/scg_pkg.sv @@
`timescale 1ns / 1ps

package scg_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int IDX_W        = $clog2(MAX_CLUSTERS);
	localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);
	localparam int FRAC_BITS    = 10;
	localparam int POS_W        = 20;
	localparam int MEAN_W       = POS_W + FRAC_BITS;
	localparam int DIFF_W       = MEAN_W + 1;
	localparam int SQ_W         = 2 * DIFF_W;
	localparam int ROOT_W       = DIFF_W;
	localparam int RAD_W        = 19;
	localparam int OBS_W        = 16;
	localparam int WIN_W        = 16;
	localparam int TIME_W       = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [MEAN_W-1:0] DEV_MAX = {MEAN_W{1'b1}};
	localparam logic [OBS_W-1:0]  OBS_MAX = {OBS_W{1'b1}};

	typedef enum logic [1:0] {
		F_FRAME_START = 2'd0,
		F_OBSERVE     = 2'd1,
		F_CLEAR       = 2'd2,
		F_FRAME_END   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		V_PASS     = 2'd0,
		V_SUPPRESS = 2'd1,
		V_ACK      = 2'd2
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATE_ENABLE   = 3'd0,
		CFG_MATCH_RADIUS  = 3'd1,
		CFG_STATIC_RADIUS = 3'd2,
		CFG_MIN_COUNT     = 3'd3,
		CFG_MIN_DWELL     = 3'd4,
		CFG_FORGET        = 3'd5,
		CFG_WINDOW_LEN    = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FS_RD,
		ST_FS_CHK,
		ST_FE_RD,
		ST_FE_CHK,
		ST_OB_RD,
		ST_OB_DIFF,
		ST_OB_SQX,
		ST_OB_SQY,
		ST_OB_ROOTGO,
		ST_OB_ROOT,
		ST_OB_END,
		ST_UP_RD,
		ST_UP_PREP,
		ST_UP_LAUNCH,
		ST_UP_DIV,
		ST_UP_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean_x;
		logic signed [MEAN_W-1:0] mean_y;
		logic [MEAN_W-1:0]        mean_dev;
		logic [OBS_W-1:0]         obs_count;
		logic [TIME_W-1:0]        first_time;
		logic [TIME_W-1:0]        last_time;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	// Time since t, clamped at zero when the clock has gone backwards.
	function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
	                                              input logic [TIME_W-1:0] t);
		return (now >= t) ? (now - t) : '0;
	endfunction

	function automatic logic entry_is_still(input entry_t e,
	                                        input logic [OBS_W-1:0] min_count,
	                                        input logic [RAD_W-1:0] static_radius,
	                                        input logic [TIME_W-1:0] min_dwell,
	                                        input logic [TIME_W-1:0] now);
		logic [MEAN_W-1:0] rad_scaled;
		rad_scaled = MEAN_W'({static_radius, {FRAC_BITS{1'b0}}});
		return (e.obs_count >= min_count) && (e.mean_dev <= rad_scaled) &&
		       (elapsed(now, e.first_time) >= min_dwell);
	endfunction

endpackage

@@ sv/scg_table.sv @@
`timescale 1ns / 1ps

module scg_table import scg_pkg::*; (
	input  logic             clk,
	input  tbl_wr_t          wr,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [MAX_CLUSTERS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/scg_isqrt.sv @@
`timescale 1ns / 1ps

module scg_isqrt import scg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   operand,
	output logic [ROOT_W-1:0] root,
	output logic              done
);

	localparam int TOP_BIT = ((SQ_W - 1) / 2) * 2;

	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] n_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W:0]   trial;
	logic            take;

	// One result bit per cycle, classic digit-by-digit root.
	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign take  = {1'b0, n_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= operand;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << TOP_BIT;
		end else if (busy_q) begin
			if (take) begin
				n_q <= n_q - trial[SQ_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = r_q[ROOT_W-1:0];
	assign done = done_q;

endmodule

@@ sv/scg_div.sv @@
`timescale 1ns / 1ps

module scg_div import scg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIFF_W-1:0] dividend,
	input  logic [WIN_W-1:0]         divisor,
	output logic signed [DIFF_W-1:0] quotient,
	output logic                     done
);

	localparam int STEP_W = $clog2(DIFF_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [WIN_W-1:0]  rem_q;
	logic [DIFF_W-1:0] quo_q;
	logic [WIN_W-1:0]  dvs_q;
	logic              neg_q;
	logic [WIN_W:0]    rem_sh;
	logic [WIN_W:0]    rem_sub;
	logic              ge;

	// Restoring division on the magnitude, truncating toward zero.
	assign rem_sh  = {rem_q, quo_q[DIFF_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIFF_W-1];
			quo_q <= dividend[DIFF_W-1] ? DIFF_W'(-dividend) : DIFF_W'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
			cnt_q <= STEP_W'(DIFF_W - 1);
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
			quo_q <= {quo_q[DIFF_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign done     = done_q;

endmodule

@@ sv/static_cluster_gate_top.sv @@
`timescale 1ns / 1ps
// Clear and a skipped group go straight to the result; frame start and frame end sweep the
// held clusters once (a frame start with the gate off skips the sweep). Observe searches every
// held cluster with a bit-serial root, then updates a matched cluster with three bit-serial
// divisions. One request is in work at a time; the next is taken in the cycle after the result
// is loaded, and a finished result waits until the output register is free. Reset clears the
// held count, the frame time and the output valid flag, and loads the configuration defaults.

module static_cluster_gate_top import scg_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic signed [POS_W-1:0]      pos_x,
	input  logic signed [POS_W-1:0]      pos_y,
	input  logic                         placed,
	input  logic [TIME_W-1:0]            time_stamp,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   verdict,
	output logic                         created,
	output logic [CNT_W-1:0]             held_count,
	output logic [CNT_W-1:0]             still_count
);

	// Configuration registers.
	logic              gate_en_q;
	logic [RAD_W-1:0]  match_radius_q;
	logic [RAD_W-1:0]  static_radius_q;
	logic [OBS_W-1:0]  min_count_q;
	logic [TIME_W-1:0] min_dwell_q;
	logic [TIME_W-1:0] forget_q;
	logic [WIN_W-1:0]  window_q;

	// Control state.
	state_t            st_q, st_d;
	logic [CNT_W-1:0]  total_q;
	logic [TIME_W-1:0] frame_time_q;
	logic              out_valid_q;

	// Request and sweep registers.
	func_t                    func_q;
	logic signed [MEAN_W-1:0] px_q, py_q;
	logic [CNT_W-1:0]         k_q, j_q, sc_q;
	logic                     found_q;
	logic [ROOT_W-1:0]        best_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     created_q;
	verdict_t                 verdict_q;
	logic [DIFF_W-1:0]        dx_mag_q, dy_mag_q;
	logic [SQ_W-1:0]          sqx_q, sqy_q;
	entry_t                   upd_q;
	logic [OBS_W-1:0]         cnt_new_q;
	logic [WIN_W-1:0]         divisor_q;
	logic [MEAN_W-1:0]        dev_q;
	logic [1:0]               ph_q;
	logic [MEAN_W-1:0]        new_dev_q;
	logic signed [MEAN_W-1:0] new_x_q, new_y_q;

	// Output registers.
	logic [1:0]       verdict_o_q;
	logic             created_o_q;
	logic [CNT_W-1:0] tracked_o_q;
	logic [CNT_W-1:0] static_o_q;

	// Table and arithmetic units.
	tbl_wr_t                  tbl_wr;
	logic [IDX_W-1:0]         tbl_raddr;
	entry_t                   rd;
	logic                     sq_start, sq_done;
	logic [ROOT_W-1:0]        sq_root;
	logic                     div_start, div_done;
	logic signed [DIFF_W-1:0] div_dividend, div_quot;

	logic                     in_acc;
	logic                     out_free;
	logic                     keep;
	logic                     room;
	logic [ROOT_W-1:0]        limit;
	logic signed [DIFF_W-1:0] dx_diff, dy_diff;
	logic [OBS_W-1:0]         cnt_inc;
	logic [WIN_W-1:0]         div_min;
	logic                     wins;

	scg_table u_table (
		.clk   (clk),
		.wr    (tbl_wr),
		.raddr (tbl_raddr),
		.rdata (rd)
	);

	scg_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sqx_q + sqy_q),
		.root    (sq_root),
		.done    (sq_done)
	);

	scg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (divisor_q),
		.quotient (div_quot),
		.done     (div_done)
	);

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign room     = total_q < CNT_W'(MAX_CLUSTERS);
	assign limit    = ROOT_W'({match_radius_q, {FRAC_BITS{1'b0}}});

	// A cluster survives frame start unless it has gone unseen too long.
	assign keep = !(elapsed(frame_time_q, rd.last_time) > forget_q);

	// Component distances between a stored mean and the group.
	assign dx_diff = DIFF_W'(rd.mean_x) - DIFF_W'(px_q);
	assign dy_diff = DIFF_W'(rd.mean_y) - DIFF_W'(py_q);

	// A strictly nearer cluster wins, so ties keep the earliest one.
	assign wins = (sq_root <= limit) && (!found_q || (sq_root < best_q));

	// Saturating count and the averaging divisor; a zero divisor is raised to one when registered.
	assign cnt_inc = (rd.obs_count < OBS_MAX) ? rd.obs_count + 1'b1 : rd.obs_count;
	assign div_min = (cnt_inc < window_q) ? cnt_inc : window_q;

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func_t'(func))
						F_FRAME_START: st_d = gate_en_q ? ST_FS_RD : ST_DONE;
						F_OBSERVE:     st_d = (gate_en_q && placed) ? ST_OB_RD : ST_DONE;
						F_FRAME_END:   st_d = ST_FE_RD;
						default:       st_d = ST_DONE;
					endcase
				end
			end
			ST_FS_RD:     st_d = (k_q == total_q) ? ST_DONE : ST_FS_CHK;
			ST_FS_CHK:    st_d = ST_FS_RD;
			ST_FE_RD:     st_d = (k_q == total_q) ? ST_DONE : ST_FE_CHK;
			ST_FE_CHK:    st_d = ST_FE_RD;
			ST_OB_RD:     st_d = (k_q == total_q) ? ST_OB_END : ST_OB_DIFF;
			ST_OB_DIFF:   st_d = ST_OB_SQX;
			ST_OB_SQX:    st_d = ST_OB_SQY;
			ST_OB_SQY:    st_d = ST_OB_ROOTGO;
			ST_OB_ROOTGO: st_d = ST_OB_ROOT;
			ST_OB_ROOT:   st_d = sq_done ? ST_OB_RD : ST_OB_ROOT;
			ST_OB_END:    st_d = found_q ? ST_UP_RD : ST_DONE;
			ST_UP_RD:     st_d = ST_UP_PREP;
			ST_UP_PREP:   st_d = ST_UP_LAUNCH;
			ST_UP_LAUNCH: st_d = ST_UP_DIV;
			ST_UP_DIV: begin
				if (div_done) begin
					st_d = (ph_q == 2'd2) ? ST_UP_WR : ST_UP_LAUNCH;
				end
			end
			ST_UP_WR:     st_d = ST_DONE;
			ST_DONE:      st_d = out_free ? ST_IDLE : ST_DONE;
			default:      st_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: table ports and unit starts.
	always_comb begin
		in_stall     = (st_q != ST_IDLE);
		tbl_raddr    = (st_q == ST_UP_RD) ? best_idx_q : k_q[IDX_W-1:0];
		tbl_wr       = '0;
		sq_start     = (st_q == ST_OB_ROOTGO);
		div_start    = (st_q == ST_UP_LAUNCH);
		case (ph_q)
			2'd0:    div_dividend = DIFF_W'(dev_q) - DIFF_W'(upd_q.mean_dev);
			2'd1:    div_dividend = DIFF_W'(px_q) - DIFF_W'(upd_q.mean_x);
			default: div_dividend = DIFF_W'(py_q) - DIFF_W'(upd_q.mean_y);
		endcase
		case (st_q)
			ST_FS_CHK: begin
				tbl_wr.en   = keep;
				tbl_wr.addr = j_q[IDX_W-1:0];
				tbl_wr.data = rd;
			end
			ST_OB_END: begin
				tbl_wr.en              = !found_q && room;
				tbl_wr.addr            = total_q[IDX_W-1:0];
				tbl_wr.data.mean_x     = px_q;
				tbl_wr.data.mean_y     = py_q;
				tbl_wr.data.mean_dev   = '0;
				tbl_wr.data.obs_count  = OBS_W'(1);
				tbl_wr.data.first_time = frame_time_q;
				tbl_wr.data.last_time  = frame_time_q;
			end
			ST_UP_WR: begin
				tbl_wr.en              = 1'b1;
				tbl_wr.addr            = best_idx_q;
				tbl_wr.data.mean_x     = new_x_q;
				tbl_wr.data.mean_y     = new_y_q;
				tbl_wr.data.mean_dev   = new_dev_q;
				tbl_wr.data.obs_count  = cnt_new_q;
				tbl_wr.data.first_time = upd_q.first_time;
				tbl_wr.data.last_time  = frame_time_q;
			end
			default: begin
				tbl_wr = '0;
			end
		endcase
	end

	// Control registers, configuration and the output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= ST_IDLE;
			total_q         <= '0;
			frame_time_q    <= '0;
			out_valid_q     <= 1'b0;
			gate_en_q       <= 1'b1;
			match_radius_q  <= RAD_W'(512);
			static_radius_q <= RAD_W'(51);
			min_count_q     <= OBS_W'(10);
			min_dwell_q     <= TIME_W'(2000);
			forget_q        <= TIME_W'(1000);
			window_q        <= WIN_W'(30);
		end else begin
			st_q <= st_d;
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GATE_ENABLE:   gate_en_q       <= cfg_wr_data[0];
					CFG_MATCH_RADIUS:  match_radius_q  <= cfg_wr_data[RAD_W-1:0];
					CFG_STATIC_RADIUS: static_radius_q <= cfg_wr_data[RAD_W-1:0];
					CFG_MIN_COUNT:     min_count_q     <= cfg_wr_data[OBS_W-1:0];
					CFG_MIN_DWELL:     min_dwell_q     <= cfg_wr_data[TIME_W-1:0];
					CFG_FORGET:        forget_q        <= cfg_wr_data[TIME_W-1:0];
					CFG_WINDOW_LEN:    window_q        <= cfg_wr_data[WIN_W-1:0];
					default:           ;
				endcase
			end
			if (in_acc) begin
				if (func_t'(func) == F_FRAME_START) begin
					frame_time_q <= time_stamp;
				end
				if (func_t'(func) == F_CLEAR) begin
					total_q <= '0;
				end
			end
			// The compaction sweep ends with the survivors packed at the front.
			if ((st_q == ST_FS_RD) && (k_q == total_q)) begin
				total_q <= j_q;
			end
			if ((st_q == ST_OB_END) && !found_q && room) begin
				total_q <= total_q + 1'b1;
			end
			if ((st_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					func_q    <= func_t'(func);
					px_q      <= {pos_x, {FRAC_BITS{1'b0}}};
					py_q      <= {pos_y, {FRAC_BITS{1'b0}}};
					k_q       <= '0;
					j_q       <= '0;
					sc_q      <= '0;
					found_q   <= 1'b0;
					created_q <= 1'b0;
					verdict_q <= (func_t'(func) == F_OBSERVE) ? V_PASS : V_ACK;
				end
			end
			ST_FS_CHK: begin
				k_q <= k_q + 1'b1;
				if (keep) begin
					j_q <= j_q + 1'b1;
				end
			end
			ST_FE_CHK: begin
				k_q <= k_q + 1'b1;
				if (entry_is_still(rd, min_count_q, static_radius_q, min_dwell_q,
				                   frame_time_q)) begin
					sc_q <= sc_q + 1'b1;
				end
			end
			ST_OB_DIFF: begin
				dx_mag_q <= dx_diff[DIFF_W-1] ? DIFF_W'(-dx_diff) : DIFF_W'(dx_diff);
				dy_mag_q <= dy_diff[DIFF_W-1] ? DIFF_W'(-dy_diff) : DIFF_W'(dy_diff);
			end
			ST_OB_SQX: begin
				sqx_q <= SQ_W'(dx_mag_q) * SQ_W'(dx_mag_q);
			end
			ST_OB_SQY: begin
				sqy_q <= SQ_W'(dy_mag_q) * SQ_W'(dy_mag_q);
			end
			ST_OB_ROOT: begin
				if (sq_done) begin
					k_q <= k_q + 1'b1;
					if (wins) begin
						found_q    <= 1'b1;
						best_q     <= sq_root;
						best_idx_q <= k_q[IDX_W-1:0];
					end
				end
			end
			ST_OB_END: begin
				if (!found_q && room) begin
					created_q <= 1'b1;
				end
			end
			ST_UP_PREP: begin
				// The verdict is taken from the cluster as it stood before this group.
				upd_q     <= rd;
				cnt_new_q <= cnt_inc;
				divisor_q <= (div_min == '0) ? WIN_W'(1) : div_min;
				dev_q     <= (best_q > ROOT_W'(DEV_MAX)) ? DEV_MAX : best_q[MEAN_W-1:0];
				ph_q      <= 2'd0;
				if (entry_is_still(rd, min_count_q, static_radius_q, min_dwell_q,
				                   frame_time_q)) begin
					verdict_q <= V_SUPPRESS;
				end
			end
			ST_UP_DIV: begin
				if (div_done) begin
					case (ph_q)
						2'd0:    new_dev_q <= upd_q.mean_dev + div_quot[MEAN_W-1:0];
						2'd1:    new_x_q   <= upd_q.mean_x + MEAN_W'(div_quot);
						default: new_y_q   <= upd_q.mean_y + MEAN_W'(div_quot);
					endcase
					ph_q <= ph_q + 1'b1;
				end
			end
			default: ;
		endcase
		if ((st_q == ST_DONE) && out_free) begin
			verdict_o_q <= verdict_q;
			created_o_q <= created_q;
			tracked_o_q <= total_q;
			static_o_q  <= (func_q == F_FRAME_END) ? sc_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_o_q;
	assign created     = created_o_q;
	assign held_count  = tracked_o_q;
	assign still_count = static_o_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_CLUSTERS))
		else $error("cluster count exceeds the table depth");

	a_created_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && created) |-> (verdict == V_PASS))
		else $error("a newly opened cluster must pass its group");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FS_CHK) |-> (j_q <= k_q))
		else $error("compaction write index ran ahead of the read index");

	a_update_target: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UP_WR) |-> (found_q && (CNT_W'(best_idx_q) < total_q)))
		else $error("update written to an entry outside the table");

	a_ack_no_create: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_DONE) && (func_q != F_OBSERVE)) |-> (!created_q && (verdict_q == V_ACK)))
		else $error("a command request must be acknowledged without opening a cluster");

endmodule
